@@ rtl/lpd_pkg.sv @@
package lpd_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned HdrCntW = $clog2(HeaderBytes);
  localparam int unsigned AccW = (HeaderBytes - 1) * 8;
  localparam logic [31:0] MaxSizeReset = 32'h0001_0000;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_NOTICE  = 1'b1
  } out_kind_e;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [7:0]  payload_byte;
    logic [31:0] byte_index;
    logic        last_byte;
    logic [31:0] message_length;
  } result_t;

endpackage

@@ rtl/lpd_byte_if.sv @@
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

@@ rtl/lpd_result_if.sv @@
interface lpd_result_if;
  logic                 valid;
  logic                 ready;
  lpd_pkg::out_kind_e   out_kind;
  logic [7:0]           payload_byte;
  logic [31:0]          byte_index;
  logic                 last_byte;
  logic [31:0]          message_length;

  modport source (
    output valid, output out_kind, output payload_byte, output byte_index,
    output last_byte, output message_length, input ready
  );
  modport sink (
    input valid, input out_kind, input payload_byte, input byte_index,
    input last_byte, input message_length, output ready
  );
endinterface

@@ rtl/lpd_parser.sv @@
module lpd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output lpd_pkg::result_t res_o
);
  import lpd_pkg::*;

  logic [31:0]        max_q;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [AccW-1:0]    hdr_acc_q, hdr_acc_d;
  logic [31:0]        cur_len_q, cur_len_d;
  logic [31:0]        remain_q, remain_d;
  logic [31:0]        wpos_q, wpos_d;
  logic               discard_q, discard_d;

  logic               in_header;
  logic               hdr_done;
  logic [31:0]        len;
  logic [AccW+7:0]    shifted;

  assign in_header = (remain_q == 32'd0);
  assign hdr_done  = in_header && (hdr_cnt_q == HdrCntW'(HeaderBytes - 1));
  assign len       = {hdr_acc_q, byte_i};
  assign shifted   = {hdr_acc_q, byte_i};

  always_comb begin
    hdr_cnt_d   = hdr_cnt_q;
    hdr_acc_d   = hdr_acc_q;
    cur_len_d   = cur_len_q;
    remain_d    = remain_q;
    wpos_d      = wpos_q;
    discard_d   = discard_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (!in_header) begin
        wpos_d   = wpos_q + 32'd1;
        remain_d = remain_q - 32'd1;
        if (!discard_q) begin
          res_valid_o          = 1'b1;
          res_o.out_kind       = KIND_PAYLOAD;
          res_o.payload_byte   = byte_i;
          res_o.byte_index     = wpos_q;
          res_o.last_byte      = (remain_q == 32'd1);
          res_o.message_length = cur_len_q;
        end
      end else if (!hdr_done) begin
        hdr_acc_d = shifted[AccW-1:0];
        hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
      end else begin
        hdr_cnt_d = '0;
        hdr_acc_d = '0;
        cur_len_d = len;
        remain_d  = len;
        wpos_d    = 32'd0;
        discard_d = (len > max_q);
        if (len > max_q) begin
          res_valid_o          = 1'b1;
          res_o.out_kind       = KIND_NOTICE;
          res_o.message_length = len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= MaxSizeReset;
      hdr_cnt_q <= '0;
      hdr_acc_q <= '0;
      cur_len_q <= '0;
      remain_q  <= '0;
      wpos_q    <= '0;
      discard_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      hdr_cnt_q <= hdr_cnt_d;
      hdr_acc_q <= hdr_acc_d;
      cur_len_q <= cur_len_d;
      remain_q  <= remain_d;
      wpos_q    <= wpos_d;
      discard_q <= discard_d;
    end
  end

  // The payload counters always add up to the header length.
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remain_q + wpos_q) == cur_len_q)
    else $error("remaining and written byte counts disagree with length");

  a_hdr_only_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q != '0) |-> (remain_q == 32'd0))
    else $error("header bytes gathered while payload is pending");

  a_notice_discards: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_kind == KIND_NOTICE) |=> discard_q)
    else $error("oversized notice not followed by discarding");

endmodule

@@ rtl/lpd_out_buf.sv @@
module lpd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpd_pkg::result_t data_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lpd_pkg::result_t out_data_o
);
  import lpd_pkg::*;

  logic    main_valid_q;
  logic    skid_valid_q;
  result_t main_q;
  result_t skid_q;
  logic    pop;

  assign pop         = main_valid_q && out_ready_i;
  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held while output entry is empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && skid_valid_q))
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (!skid_valid_q && main_valid_q))
    else $error("skid entry did not move to the output");

endmodule

@@ rtl/length_prefix_deframer.sv @@
// Splits a byte stream into messages, each led by a 4-byte big-endian length header.
// A message longer than the configured maximum is discarded and a notice is output.
// One byte is accepted per clock while the output buffer has room. A two-entry output
// buffer registers results and holds them while the output is stalled; input ready
// depends only on its registered fill, so input flows until two results are waiting.
module length_prefix_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  lpd_byte_if.sink     in_i,
  lpd_result_if.source out_o
);
  import lpd_pkg::*;

  logic    accept;
  logic    buf_ready;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  lpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_i.stream_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.out_kind       = out_data.out_kind;
  assign out_o.payload_byte   = out_data.payload_byte;
  assign out_o.byte_index     = out_data.byte_index;
  assign out_o.last_byte      = out_data.last_byte;
  assign out_o.message_length = out_data.message_length;

endmodule
